FILE: hdl/utf8sd_pkg.sv
// utf8sd_pkg: shared constants and types of the utf8 stream decoder
`default_nettype none

package utf8sd_pkg;

    // longest legacy sequence accepted, in bytes
    localparam int unsigned MAX_SEQUENCE_BYTES = 6;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned CNT_W = 3;
    localparam int unsigned ST_W  = 2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [ST_W-1:0] ST_TRUNCATED = 2'd2;
    localparam logic [ST_W-1:0] ST_REPLACED  = 2'd3;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 31'h0000FFFD;

    // output queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // one decoded result item
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] byte_count;
        logic [ST_W-1:0]  status;
        logic             last;
    } result_t;

    // results produced by one input item, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

FILE: hdl/utf8sd_ifs.sv
// utf8sd_ifs: valid/ready channel interfaces of the utf8 stream decoder
`default_nettype none

// raw byte channel
interface utf8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// decoded character channel
interface utf8sd_char_if;
    logic                               valid;
    logic                               ready;
    logic [utf8sd_pkg::CP_W-1:0]        code_point;
    logic [utf8sd_pkg::CNT_W-1:0]       byte_count;
    logic [utf8sd_pkg::ST_W-1:0]        status;
    logic                               last;

    modport source (output valid, output code_point, output byte_count, output status,
                    output last, input ready);
    modport sink   (input valid, input code_point, input byte_count, input status,
                    input last, output ready);
endinterface

// configuration write channel
interface utf8sd_cfg_if;
    logic valid;
    logic ready;
    logic replace_errors;

    modport source (output valid, output replace_errors, input ready);
    modport sink   (input valid, input replace_errors, output ready);
endinterface

`default_nettype wire

FILE: hdl/utf8sd_core.sv
// utf8sd_core: decode state, mode register and per-byte decode logic
`default_nettype none

module utf8sd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    utf8sd_byte_if.sink          stream,
    utf8sd_cfg_if.sink           cfg,
    input  wire logic            room,
    output utf8sd_pkg::push_t    push
);

    // outcome of a byte seen with no sequence open
    typedef struct packed {
        logic                        emit;
        utf8sd_pkg::result_t         res;
        logic                        open;
        logic [utf8sd_pkg::CP_W-1:0] pv;
        logic [2:0]                  el;
        logic                        skip;
    } fresh_t;

    logic [utf8sd_pkg::CP_W-1:0] pv_reg, pv_next;
    logic [2:0]                  el_reg, el_next;
    logic [2:0]                  bs_reg, bs_next;
    logic                        skip_reg, skip_next;
    logic                        repl_reg;

    // number of leading ones of a byte
    function automatic logic [3:0] lead_width(input logic [7:0] b);
        logic [3:0] w;
        unique casez (b)
            8'b0???????: w = 4'd0;
            8'b10??????: w = 4'd1;
            8'b110?????: w = 4'd2;
            8'b1110????: w = 4'd3;
            8'b11110???: w = 4'd4;
            8'b111110??: w = 4'd5;
            8'b1111110?: w = 4'd6;
            8'b11111110: w = 4'd7;
            default:     w = 4'd8;
        endcase
        return w;
    endfunction

    // error result for the current mode
    function automatic utf8sd_pkg::result_t error_result(input logic repl);
        utf8sd_pkg::result_t r;
        r = '0;
        if (repl)
        begin
            r.code_point = utf8sd_pkg::REPLACEMENT_CHAR;
            r.status     = utf8sd_pkg::ST_REPLACED;
        end
        else
        begin
            r.status = utf8sd_pkg::ST_INVALID;
        end
        return r;
    endfunction

    // byte with no sequence open, skipping rule applied
    function automatic fresh_t fresh(input logic [7:0] b, input logic eoi,
                                     input logic skip_in, input logic repl);
        fresh_t     s;
        logic [3:0] w;
        logic [7:0] mask;
        logic [4:0] sh;
        s    = '0;
        s.skip = skip_in;
        w    = lead_width(b);
        mask = 8'h7f >> w;
        sh   = 5'(w) * 5'd6 - 5'd6;
        if (!(skip_in && b[7]))
        begin
            s.skip = 1'b0;
            if (!b[7])
            begin
                s.emit           = 1'b1;
                s.res.code_point = {23'd0, b};
                s.res.byte_count = 3'd1;
                s.res.status     = utf8sd_pkg::ST_OK;
            end
            else if (w < 4'd2 || w > 4'(utf8sd_pkg::MAX_SEQUENCE_BYTES))
            begin
                s.emit = 1'b1;
                s.res  = error_result(repl);
                s.skip = repl;
            end
            else if (eoi)
            begin
                s.emit       = 1'b1;
                s.res.status = utf8sd_pkg::ST_TRUNCATED;
            end
            else
            begin
                s.open = 1'b1;
                s.el   = w[2:0];
                s.pv   = {23'd0, b & mask} << sh;
            end
        end
        return s;
    endfunction

    assign stream.ready = room;
    assign cfg.ready    = 1'b1;

    // decode one accepted byte
    always_comb
    begin
        logic                   accept;
        logic [7:0]             b;
        logic                   eoi;
        logic [2:0]             idx;
        logic [4:0]             sh;
        logic [3:0]             n;
        fresh_t                 s;
        utf8sd_pkg::result_t    r0;
        utf8sd_pkg::result_t    r1;
        logic [1:0]             cnt;

        accept = stream.valid && stream.ready;
        b      = stream.data_byte;
        eoi    = stream.end_of_input;
        idx    = el_reg - 3'd1 - bs_reg;
        sh     = 5'(idx) * 5'd6;
        n      = 4'(bs_reg) + 4'd1;
        s      = fresh(b, eoi, skip_reg, repl_reg);
        r0     = '0;
        r1     = '0;
        cnt    = 2'd0;

        pv_next   = pv_reg;
        el_next   = el_reg;
        bs_next   = bs_reg;
        skip_next = skip_reg;

        if (accept)
        begin
            if (el_reg != 3'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    // continuation byte fills in six more bits
                    if (bs_reg < el_reg)
                        pv_next = pv_reg | ({25'd0, b[5:0]} << sh);
                    bs_next = n[2:0];
                    if (n >= 4'(el_reg))
                    begin
                        r0.code_point = pv_next;
                        r0.byte_count = el_reg;
                        r0.status     = utf8sd_pkg::ST_OK;
                        cnt           = 2'd1;
                        pv_next       = '0;
                        el_next       = 3'd0;
                        bs_next       = 3'd0;
                    end
                    else if (eoi)
                    begin
                        r0.status = utf8sd_pkg::ST_TRUNCATED;
                        cnt       = 2'd1;
                        pv_next   = '0;
                        el_next   = 3'd0;
                        bs_next   = 3'd0;
                    end
                end
                else
                begin
                    // broken sequence, then the byte starts over
                    r0  = error_result(repl_reg);
                    s   = fresh(b, eoi, skip_reg | repl_reg, repl_reg);
                    r1  = s.res;
                    cnt = s.emit ? 2'd2 : 2'd1;
                    skip_next = s.skip;
                    pv_next   = s.open ? s.pv : '0;
                    el_next   = s.open ? s.el : 3'd0;
                    bs_next   = s.open ? 3'd1 : 3'd0;
                end
            end
            else
            begin
                r0  = s.res;
                cnt = s.emit ? 2'd1 : 2'd0;
                skip_next = s.skip;
                pv_next   = s.open ? s.pv : '0;
                el_next   = s.open ? s.el : 3'd0;
                bs_next   = s.open ? 3'd1 : 3'd0;
            end

            // end of stream closes any open sequence and clears skipping
            if (eoi)
            begin
                pv_next   = '0;
                el_next   = 3'd0;
                bs_next   = 3'd0;
                skip_next = 1'b0;
            end
        end

        // mark the final result of this item
        if (cnt == 2'd2)
            r1.last = 1'b1;
        else
            r0.last = 1'b1;

        push.count = cnt;
        push.r0    = r0;
        push.r1    = r1;
    end

    // decode state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            el_reg   <= 3'd0;
            bs_reg   <= 3'd0;
            skip_reg <= 1'b0;
            repl_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= pv_next;
            el_reg   <= el_next;
            bs_reg   <= bs_next;
            skip_reg <= skip_next;
            if (cfg.valid && cfg.ready)
                repl_reg <= cfg.replace_errors;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8sd_outq.sv
// utf8sd_outq: small result queue taking up to two items per cycle
`default_nettype none

module utf8sd_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire utf8sd_pkg::push_t   push,
    output logic                     room,
    utf8sd_char_if.source            chars
);

    utf8sd_pkg::result_t               mem_reg [utf8sd_pkg::QUEUE_DEPTH];
    logic [utf8sd_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [utf8sd_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [utf8sd_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                              pop;
    logic [utf8sd_pkg::QPTR_W-1:0]     wr_plus1;

    // room for a worst-case item of two results
    assign room = cnt_reg <= utf8sd_pkg::QCNT_W'(utf8sd_pkg::QUEUE_DEPTH - 2);

    assign chars.valid      = cnt_reg != '0;
    assign chars.code_point = mem_reg[rd_reg].code_point;
    assign chars.byte_count = mem_reg[rd_reg].byte_count;
    assign chars.status     = mem_reg[rd_reg].status;
    assign chars.last       = mem_reg[rd_reg].last;

    assign pop      = chars.valid && chars.ready;
    assign wr_plus1 = wr_reg + utf8sd_pkg::QPTR_W'(1);

    // pointer and fill updates
    always_comb
    begin
        wr_next  = wr_reg + utf8sd_pkg::QPTR_W'(push.count);
        rd_next  = pop ? rd_reg + utf8sd_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + utf8sd_pkg::QCNT_W'(push.count)
                   - utf8sd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_plus1] <= push.r1;
    end

endmodule

`default_nettype wire

FILE: hdl/utf8_stream_decoder.sv
// utf8_stream_decoder: legacy six-byte utf-8 decoder, one byte per item
//
// stream carries one raw byte per item plus an end_of_input flag; chars
// carries decoded results (code point, byte count, status, last flag);
// cfg writes the replace_errors mode bit, meant to be written while no item
// is in flight; a change inside an open sequence applies at the next error.
// A byte is decoded in the cycle it is accepted and its results are written
// into a four-entry output queue that drives chars. One byte is accepted
// per cycle as long as at least two queue entries are free; a byte that
// gives two results (a broken sequence followed by a restart) takes two
// queue entries, so the queue drain rate of one result per cycle while
// chars is ready sets the sustained byte rate.
// When chars stalls the queue fills and stream.ready drops once fewer than
// two entries are free; nothing is lost or repeated.
// Reset empties the queue, closes any open sequence, clears skipping and
// selects strict mode. No clearing pass is needed after reset.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    utf8sd_byte_if.sink     stream,
    utf8sd_cfg_if.sink      cfg,
    utf8sd_char_if.source   chars
);

    utf8sd_pkg::push_t push;
    logic              room;

    // decode logic and state
    utf8sd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .cfg    (cfg),
        .room   (room),
        .push   (push)
    );

    // result queue
    utf8sd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .chars (chars)
    );

`ifndef ASSERT_OFF
    // results appear only for an accepted byte
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (stream.valid && stream.ready))
        else $error("results pushed without an accepted item");

    // of two results from one byte the first is always an error
    a_pair_starts_error: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.r0.status == utf8sd_pkg::ST_INVALID ||
                                  push.r0.status == utf8sd_pkg::ST_REPLACED))
        else $error("two results without a leading error");

    // a good character has a legal length
    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.status == utf8sd_pkg::ST_OK) |->
        (chars.byte_count != 3'd0 &&
         chars.byte_count <= 3'(utf8sd_pkg::MAX_SEQUENCE_BYTES)))
        else $error("ok result with bad byte count");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: self-checking testbench of the utf8 stream decoder, strict and replacing modes
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // decoder state mirror and the queue of characters still owed by the block
    class char_tracker;
        bit                          replace_mode = 1'b0;
        logic [utf8sd_pkg::CP_W-1:0] partial      = '0;
        int unsigned                 seq_len      = 0;
        int unsigned                 seq_seen     = 0;
        bit                          skipping     = 1'b0;
        utf8sd_pkg::result_t         pending_chars[$];
        utf8sd_pkg::result_t         step_out[$];
        int unsigned                 byte_total   = 0;
        int unsigned                 char_total   = 0;
        int unsigned                 errors       = 0;
        int unsigned                 status_seen[4];

        function void close_seq();
            partial  = '0;
            seq_len  = 0;
            seq_seen = 0;
        endfunction

        function void push_char(logic [utf8sd_pkg::CP_W-1:0] cp, int unsigned len,
                                logic [utf8sd_pkg::ST_W-1:0] st);
            utf8sd_pkg::result_t r;
            r.code_point = cp;
            r.byte_count = utf8sd_pkg::CNT_W'(len);
            r.status     = st;
            r.last       = 1'b0;
            step_out.push_back(r);
        endfunction

        function void flag_error();
            close_seq();
            if (replace_mode)
            begin
                push_char(utf8sd_pkg::REPLACEMENT_CHAR, 0, utf8sd_pkg::ST_REPLACED);
                skipping = 1'b1;
            end
            else
                push_char('0, 0, utf8sd_pkg::ST_INVALID);
        endfunction

        function int unsigned lead_ones(logic [7:0] b);
            int unsigned n;
            n = 0;
            while (n < 8 && b[7-n])
                n++;
            return n;
        endfunction

        // byte seen with no sequence open and not skipping
        function void start_char(logic [7:0] b, bit eoi);
            int unsigned w;
            if (b < 8'h80)
            begin
                push_char(utf8sd_pkg::CP_W'(b), 1, utf8sd_pkg::ST_OK);
                return;
            end
            if (b[7:6] == 2'b10)
            begin
                flag_error();
                return;
            end
            w = lead_ones(b);
            if (w < 2 || w > utf8sd_pkg::MAX_SEQUENCE_BYTES)
            begin
                flag_error();
                return;
            end
            partial  = utf8sd_pkg::CP_W'((32'(b) & (32'h7f >> w)) << (6 * (w - 1)));
            seq_len  = w;
            seq_seen = 1;
            if (eoi)
            begin
                close_seq();
                push_char('0, 0, utf8sd_pkg::ST_TRUNCATED);
            end
        endfunction

        // returns 1 when the skipping rule swallows the byte
        function bit fresh_byte(logic [7:0] b, bit eoi);
            if (skipping)
            begin
                if (b > 8'h7f)
                    return 1'b1;
                skipping = 1'b0;
            end
            start_char(b, eoi);
            return 1'b0;
        endfunction

        // accepted input item; returns 1 when the block merely drops it
        function bit take_byte(logic [7:0] b, bit eoi);
            bit                          dropped;
            logic [utf8sd_pkg::CP_W-1:0] cp;
            int unsigned                 w;
            dropped = 1'b0;
            step_out.delete();
            byte_total++;
            if (seq_len != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    if (seq_seen < seq_len)
                        partial |= utf8sd_pkg::CP_W'(
                            32'(b[5:0]) << (6 * (seq_len - 1 - seq_seen)));
                    seq_seen++;
                    if (seq_seen >= seq_len)
                    begin
                        cp = partial;
                        w  = seq_len;
                        close_seq();
                        push_char(cp, w, utf8sd_pkg::ST_OK);
                    end
                    else if (eoi)
                    begin
                        close_seq();
                        push_char('0, 0, utf8sd_pkg::ST_TRUNCATED);
                    end
                end
                else
                begin
                    flag_error();
                    void'(fresh_byte(b, eoi));
                end
            end
            else
                dropped = fresh_byte(b, eoi);
            if (eoi)
            begin
                close_seq();
                skipping = 1'b0;
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                pending_chars.push_back(step_out[i]);
            return dropped && !eoi;
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t mismatch in %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
        endfunction

        // accepted result item against the oldest expected character
        function void match_char(utf8sd_pkg::result_t got);
            utf8sd_pkg::result_t want;
            if (pending_chars.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result cp=0x%0h count=%0d status=%0d last=%0b",
                         $time, got.code_point, got.byte_count, got.status, got.last);
                return;
            end
            want = pending_chars.pop_front();
            char_total++;
            status_seen[got.status]++;
            if (got.code_point != want.code_point)
                report_field("code_point", 32'(want.code_point), 32'(got.code_point));
            if (got.byte_count != want.byte_count)
                report_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
            if (got.status != want.status)
                report_field("status", 32'(want.status), 32'(got.status));
            if (got.last != want.last)
                report_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    utf8sd_byte_if stream_if ();
    utf8sd_cfg_if  cfg_if ();
    utf8sd_char_if chars_if ();

    utf8_stream_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .cfg    (cfg_if),
        .chars  (chars_if)
    );

    char_tracker tracker = new;

    int unsigned         burst_left     = 0;
    int unsigned         counted_items  = 0;
    int unsigned         decoding_items = 0;
    int unsigned         hold_requests  = 0;
    int unsigned         hold_count     = 0;
    int unsigned         mode_writes    = 0;
    int unsigned         cycle_count    = 0;
    utf8sd_pkg::result_t seen_char;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stall epochs, plus long hold-offs on request
    initial
    begin : receiver
        int unsigned stall_pct;
        int unsigned epoch_left;
        int unsigned hold_left;
        stall_pct  = 0;
        epoch_left = 0;
        hold_left  = 0;
        chars_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests > 0 && hold_left == 0)
            begin
                hold_requests--;
                hold_count++;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                if (epoch_left == 0)
                begin
                    epoch_left = $urandom_range(20, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                epoch_left--;
                chars_if.ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            seen_char.code_point = chars_if.code_point;
            seen_char.byte_count = chars_if.byte_count;
            seen_char.status     = chars_if.status;
            seen_char.last       = chars_if.last;
            tracker.match_char(seen_char);
        end
    end

    // offer one byte, in bursts with random gaps, and wait for its handshake
    task automatic send_byte(input logic [7:0] b, input bit eoi);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        stream_if.valid        <= 1'b1;
        stream_if.data_byte    <= b;
        stream_if.end_of_input <= eoi;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        if (!tracker.take_byte(b, eoi))
            decoding_items++;
        counted_items++;
    endtask

    // write the mode bit once every owed character is out
    task automatic write_mode(input bit v);
        stream_if.valid <= 1'b0;
        while (tracker.pending_chars.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.replace_errors <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        tracker.replace_mode = v;
        cfg_if.valid <= 1'b0;
        mode_writes++;
    endtask

    function automatic bit rand_eoi();
        return ($urandom_range(0, 49) == 0);
    endfunction

    // lead byte of a w-byte sequence with random payload bits
    function automatic logic [7:0] lead_byte(int unsigned w);
        logic [7:0] ones;
        if (w == 1)
            return 8'($urandom_range(0, 127));
        ones = 8'hff << (8 - w);
        return ones | (8'($urandom) & (8'h7f >> w));
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // mostly well-formed characters, the rest broken sequences and noise
    task automatic send_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned w;
        int unsigned cut;
        int unsigned k;
        int unsigned nb;
        stop_at = counted_items + target;
        while (counted_items < stop_at)
        begin
            pick = $urandom_range(1, 100);
            if (pick <= 72)
            begin
                // complete character, short lengths favored
                k = $urandom_range(1, 100);
                w = (k <= 30) ? 1 : (k <= 50) ? 2 : (k <= 68) ? 3 :
                    (k <= 82) ? 4 : (k <= 92) ? 5 : 6;
                send_byte(lead_byte(w), rand_eoi());
                for (k = 1; k < w; k++)
                    send_byte(cont_byte(), rand_eoi());
            end
            else if (pick <= 84)
            begin
                // sequence cut short by ascii or a lead byte
                w   = $urandom_range(2, utf8sd_pkg::MAX_SEQUENCE_BYTES);
                cut = $urandom_range(1, w - 1);
                send_byte(lead_byte(w), rand_eoi());
                for (k = 1; k < cut; k++)
                    send_byte(cont_byte(), rand_eoi());
                nb = $urandom_range(0, 191);
                if (nb >= 128)
                    nb += 64;
                send_byte(8'(nb), rand_eoi());
            end
            else if (pick <= 92)
                send_byte(8'($urandom_range(0, 255)), rand_eoi());
            else if (pick <= 96)
                send_byte(8'($urandom_range(8'h80, 8'hbf)), rand_eoi());
            else
                send_byte(8'($urandom_range(8'hfe, 8'hff)), rand_eoi());
        end
    endtask

    // main sequence
    initial
    begin : main
        int unsigned guard;
        rst_n                  <= 1'b0;
        stream_if.valid        <= 1'b0;
        stream_if.data_byte    <= 8'h00;
        stream_if.end_of_input <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.replace_errors  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // strict mode: ascii extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        // largest two-byte and six-byte values
        send_byte(8'hdf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hfd, 1'b0);
        repeat (5) send_byte(8'hbf, 1'b0);
        // lone continuation and over-long lead bytes
        send_byte(8'h80, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'hff, 1'b0);
        // broken sequence restarted by ascii, then by a bad lead
        send_byte(8'he2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hf8, 1'b0);
        send_byte(8'hff, 1'b0);
        // broken sequence whose new lead meets end of input
        send_byte(8'hc3, 1'b0);
        send_byte(8'hf0, 1'b1);
        // truncated mid-sequence
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        // mode switched while a sequence is open
        send_byte(8'he2, 1'b0);
        write_mode(1'b1);
        send_byte(8'h41, 1'b0);
        // replacing mode: lone continuation, skipped lead, ascii resumes
        send_byte(8'hbf, 1'b0);
        send_byte(8'hc2, 1'b0);
        send_byte(8'h42, 1'b0);

        write_mode(1'b0);
        hold_requests++;
        send_random(300);
        send_byte(lead_byte(4), 1'b0);
        write_mode(1'b1);
        send_random(300);
        write_mode(1'b0);
        send_random(300);
        write_mode(1'b1);
        hold_requests++;
        send_random(350);

        // drain
        stream_if.valid <= 1'b0;
        guard = 0;
        while (tracker.pending_chars.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (tracker.pending_chars.size() != 0)
        begin
            tracker.errors++;
            $display("%0t %0d expected results never arrived", $time,
                     tracker.pending_chars.size());
        end

        $display("run: %0d bytes (%0d decoding), %0d results: %0d ok, %0d invalid, %0d truncated",
                 tracker.byte_total, decoding_items, tracker.char_total,
                 tracker.status_seen[utf8sd_pkg::ST_OK],
                 tracker.status_seen[utf8sd_pkg::ST_INVALID],
                 tracker.status_seen[utf8sd_pkg::ST_TRUNCATED]);
        $display("%0d replaced; mode bit written %0d times, %0d long output stalls",
                 tracker.status_seen[utf8sd_pkg::ST_REPLACED], mode_writes, hold_count);
        if (tracker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
